[hw/rtl/nru_page_buffer_replacement_assert.svh]
// ----------------------------------------------------------------------------
// nru page buffer assertion macros
// shared property shapes for the slot directory checks
// ----------------------------------------------------------------------------
`ifndef NRU_PAGE_BUFFER_REPLACEMENT_ASSERT_SVH
`define NRU_PAGE_BUFFER_REPLACEMENT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define NRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define NRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/nru_pkg.sv]
// ----------------------------------------------------------------------------
// nru_pkg
// shared constants and helpers of the nru page slot directory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nru_pkg;

  // operation codes
  localparam logic [1:0] OP_ACCESS   = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_SET_ROOT = 2'd2;

  // use classes
  localparam logic [1:0] CLS_NONE     = 2'd0;
  localparam logic [1:0] CLS_MODIFIED = 2'd1;
  localparam logic [1:0] CLS_ACCESSED = 2'd2;
  localparam logic [1:0] CLS_BOTH     = 2'd3;

  // field widths of the stream words
  localparam int FIELD_PAGE_W  = 16;
  localparam int FIELD_SLOT_W  = 4;
  localparam int FIELD_COUNT_W = 32;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 88;

  // tie-break lfsr
  localparam int               LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

  typedef logic [1:0] cls_t;

  // fibonacci lfsr, taps 16,14,13,11
  function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LFSR_W-1:1]};
  endfunction

  // combine an access class into a stored class
  function automatic cls_t merge_class(input cls_t old_cls, input cls_t new_cls);
    cls_t res;
    res = new_cls;
    if (old_cls == CLS_BOTH) res = CLS_BOTH;
    if (old_cls == CLS_MODIFIED && new_cls == CLS_ACCESSED) res = CLS_BOTH;
    if (old_cls == CLS_ACCESSED && new_cls == CLS_MODIFIED) res = CLS_BOTH;
    return res;
  endfunction

endpackage

[hw/rtl/nru_slot_mem.sv]
// ----------------------------------------------------------------------------
// nru_slot_mem
// slot table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nru_slot_mem #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 18
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/nru_mod.sv]
// ----------------------------------------------------------------------------
// nru_mod
// bit-serial remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nru_mod #(
  parameter int DVD_W = 16,
  parameter int DIV_W = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DIV_W-1:0]  div_r, div_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W:0]    trial;

  // restoring step: bring in next bit, subtract when it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[DVD_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      div_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt  = {dvd_r[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = DIV_W'(trial);
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // operands
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[hw/rtl/nru_page_buffer_replacement.sv]
// ----------------------------------------------------------------------------
// nru_page_buffer_replacement
// page slot directory with not-recently-used replacement
//
//   channel  dir  ports                          word
//   in       in   in_tvalid/in_tready/in_tdata   operation, page_number, use_kind
//   out      out  out_tvalid/out_tready/out_tdata hit .. fault_count
//
// one word at a time; a scan reads every slot from the slot memory, one slot
// per cycle, for hits, fills, deletes and root changes alike. an eviction adds
// a bit-serial remainder for the random tie break and a second slot pass.
// reset is synchronous, active low; slot 0 then holds root page 0, class 1.
// input is taken again while a result waits in the output register; a stalled
// output holds the next result in the final state until the register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nru_page_buffer_replacement_assert.svh"

module nru_page_buffer_replacement
  import nru_pkg::*;
#(
  parameter int SLOTS     = 5,
  parameter int PAGE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // operation[1:0], page_number[17:2], use_kind[19:18], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit[0], slot[4:1], found[5], writeback[6], writeback_page[22:7],
  // hit_count[54:23], fault_count[86:55], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ENT_W  = PAGE_BITS + 2;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCAN   = 4'd1;
  localparam logic [3:0] ST_SLAST  = 4'd2;
  localparam logic [3:0] ST_DECIDE = 4'd3;
  localparam logic [3:0] ST_MOD    = 4'd4;
  localparam logic [3:0] ST_PICK   = 4'd5;
  localparam logic [3:0] ST_PLAST  = 4'd6;
  localparam logic [3:0] ST_VWR    = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  // control state
  logic [3:0]        state_r, state_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic              rd_p2_r, rd_p2_nxt;
  logic [SLOTS-1:0]  slot_valid_r, slot_valid_nxt;
  logic [SLOTS-1:0]  wr_done_r, wr_done_nxt;
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [FIELD_COUNT_W-1:0] hits_r, hits_nxt;
  logic [FIELD_COUNT_W-1:0] faults_r, faults_nxt;
  logic              out_valid_r, out_valid_nxt;

  // request and scan payload
  logic [1:0]           op_r, op_nxt;
  logic [PAGE_BITS-1:0] page_r, page_nxt;
  cls_t                 kind_r, kind_nxt;
  logic [SLOT_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic                 mt_fnd_r, mt_fnd_nxt;
  logic [SLOT_W-1:0]    mt_idx_r, mt_idx_nxt;
  cls_t                 mt_cls_r, mt_cls_nxt;
  logic                 emp_fnd_r, emp_fnd_nxt;
  logic [SLOT_W-1:0]    emp_idx_r, emp_idx_nxt;
  cls_t                 min_cls_r, min_cls_nxt;
  logic [SLOT_W-1:0]    cls_cnt_r [4];
  logic [SLOT_W-1:0]    cls_cnt_nxt [4];
  logic [PAGE_BITS-1:0] root_page_r, root_page_nxt;
  cls_t                 root_cls_r, root_cls_nxt;
  logic [SLOT_W-1:0]    tgt_r, tgt_nxt;
  logic                 vic_fnd_r, vic_fnd_nxt;
  logic [SLOT_W-1:0]    vic_idx_r, vic_idx_nxt;
  logic [PAGE_BITS-1:0] vic_page_r, vic_page_nxt;

  // result fields
  logic                 res_hit_r, res_hit_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                 res_found_r, res_found_nxt;
  logic                 res_wb_r, res_wb_nxt;
  logic [PAGE_BITS-1:0] res_wbp_r, res_wbp_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // memory and remainder unit
  logic                 mem_we, mem_re;
  logic [SLOT_W-1:0]    mem_waddr, mem_raddr;
  logic [ENT_W-1:0]     mem_wdata, mem_rdata;
  logic                 mod_start, mod_done;
  logic [LFSR_W-1:0]    mod_dvd;
  logic [SLOT_W-1:0]    mod_rem;

  // effective read data: unwritten entries read as their reset value
  logic [PAGE_BITS-1:0] rd_page;
  cls_t                 rd_cls;
  logic                 in_acc;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = rst_n && (state_r == ST_IDLE);

  always_comb begin
    if (wr_done_r[rd_idx_r]) begin
      rd_page = mem_rdata[PAGE_BITS-1:0];
      rd_cls  = mem_rdata[ENT_W-1:PAGE_BITS];
    end else begin
      rd_page = '0;
      rd_cls  = (rd_idx_r == '0) ? CLS_MODIFIED : CLS_NONE;
    end
  end

  nru_slot_mem #(
    .DEPTH (SLOTS),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  nru_mod #(
    .DVD_W (LFSR_W),
    .DIV_W (SLOT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (mod_dvd),
    .divisor   (cls_cnt_r[min_cls_r]),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign mod_dvd = lfsr_next(lfsr_r);

  // sequencer: scan, decide, optional tie break and second pass, write back
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_p2_nxt      = rd_p2_r;
    rd_idx_nxt     = rd_idx_r;
    slot_valid_nxt = slot_valid_r;
    wr_done_nxt    = wr_done_r;
    lfsr_nxt       = lfsr_r;
    hits_nxt       = hits_r;
    faults_nxt     = faults_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    op_nxt         = op_r;
    page_nxt       = page_r;
    kind_nxt       = kind_r;
    mt_fnd_nxt     = mt_fnd_r;
    mt_idx_nxt     = mt_idx_r;
    mt_cls_nxt     = mt_cls_r;
    emp_fnd_nxt    = emp_fnd_r;
    emp_idx_nxt    = emp_idx_r;
    min_cls_nxt    = min_cls_r;
    cls_cnt_nxt    = cls_cnt_r;
    root_page_nxt  = root_page_r;
    root_cls_nxt   = root_cls_r;
    tgt_nxt        = tgt_r;
    vic_fnd_nxt    = vic_fnd_r;
    vic_idx_nxt    = vic_idx_r;
    vic_page_nxt   = vic_page_r;
    res_hit_nxt    = res_hit_r;
    res_slot_nxt   = res_slot_r;
    res_found_nxt  = res_found_r;
    res_wb_nxt     = res_wb_r;
    res_wbp_nxt    = res_wbp_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = cnt_r;
    mod_start      = 1'b0;

    // first pass: match, first free slot, lowest class and class counts
    if (rd_vld_r && !rd_p2_r) begin
      if (rd_idx_r == '0) begin
        root_page_nxt = rd_page;
        root_cls_nxt  = rd_cls;
      end
      if (!mt_fnd_r && slot_valid_r[rd_idx_r] && rd_page == page_r &&
          (op_r == OP_ACCESS || rd_idx_r != '0)) begin
        mt_fnd_nxt = 1'b1;
        mt_idx_nxt = rd_idx_r;
        mt_cls_nxt = rd_cls;
      end
      if (rd_idx_r != '0) begin
        if (!emp_fnd_r && !slot_valid_r[rd_idx_r]) begin
          emp_fnd_nxt = 1'b1;
          emp_idx_nxt = rd_idx_r;
        end
        if (rd_cls < min_cls_r) begin
          min_cls_nxt = rd_cls;
        end
        cls_cnt_nxt[rd_cls] = cls_cnt_r[rd_cls] + 1'b1;
      end
    end

    // second pass: count down to the chosen slot of lowest class
    if (rd_vld_r && rd_p2_r && !vic_fnd_r && rd_cls == min_cls_r) begin
      if (tgt_r == '0) begin
        vic_fnd_nxt  = 1'b1;
        vic_idx_nxt  = rd_idx_r;
        vic_page_nxt = rd_page;
      end else begin
        tgt_nxt = tgt_r - 1'b1;
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_tdata[1:0];
          page_nxt      = PAGE_BITS'(in_tdata[FIELD_PAGE_W+1:2]);
          kind_nxt      = in_tdata[FIELD_PAGE_W+3:FIELD_PAGE_W+2];
          mt_fnd_nxt    = 1'b0;
          emp_fnd_nxt   = 1'b0;
          vic_fnd_nxt   = 1'b0;
          min_cls_nxt   = CLS_BOTH;
          for (int c = 0; c < 4; c++) begin
            cls_cnt_nxt[c] = '0;
          end
          res_hit_nxt   = 1'b0;
          res_slot_nxt  = '0;
          res_found_nxt = 1'b0;
          res_wb_nxt    = 1'b0;
          res_wbp_nxt   = '0;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        mem_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        rd_p2_nxt  = 1'b0;
        rd_idx_nxt = cnt_r;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ST_SLAST;
        end
      end

      ST_SLAST: begin
        state_nxt = ST_DECIDE;
      end

      ST_DECIDE: begin
        state_nxt = ST_OUT;
        case (op_r)
          OP_ACCESS: begin
            if (mt_fnd_r) begin
              mem_we       = 1'b1;
              mem_waddr    = mt_idx_r;
              mem_wdata    = {merge_class(mt_cls_r, kind_r), page_r};
              wr_done_nxt[mt_idx_r] = 1'b1;
              hits_nxt     = hits_r + 1'b1;
              res_hit_nxt  = 1'b1;
              res_slot_nxt = mt_idx_r;
            end else if (emp_fnd_r) begin
              mem_we       = 1'b1;
              mem_waddr    = emp_idx_r;
              mem_wdata    = {kind_r, page_r};
              wr_done_nxt[emp_idx_r]    = 1'b1;
              slot_valid_nxt[emp_idx_r] = 1'b1;
              faults_nxt   = faults_r + 1'b1;
              res_slot_nxt = emp_idx_r;
            end else begin
              lfsr_nxt  = lfsr_next(lfsr_r);
              mod_start = 1'b1;
              state_nxt = ST_MOD;
            end
          end
          OP_DELETE: begin
            if (mt_fnd_r) begin
              slot_valid_nxt[mt_idx_r] = 1'b0;
              res_found_nxt = 1'b1;
              res_slot_nxt  = mt_idx_r;
            end
          end
          OP_SET_ROOT: begin
            mem_we         = 1'b1;
            mem_waddr      = '0;
            mem_wdata      = {root_cls_r, page_r};
            wr_done_nxt[0] = 1'b1;
            faults_nxt     = faults_r + 1'b1;
            res_wb_nxt     = 1'b1;
            res_wbp_nxt    = root_page_r;
          end
          default: begin
          end
        endcase
      end

      ST_MOD: begin
        if (mod_done) begin
          tgt_nxt   = mod_rem;
          cnt_nxt   = SLOT_W'(1);
          state_nxt = ST_PICK;
        end
      end

      ST_PICK: begin
        mem_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        rd_p2_nxt  = 1'b1;
        rd_idx_nxt = cnt_r;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == LAST_SLOT) begin
          state_nxt = ST_PLAST;
        end
      end

      ST_PLAST: begin
        state_nxt = ST_VWR;
      end

      ST_VWR: begin
        mem_we       = 1'b1;
        mem_waddr    = vic_idx_r;
        mem_wdata    = {kind_r, page_r};
        wr_done_nxt[vic_idx_r]    = 1'b1;
        slot_valid_nxt[vic_idx_r] = 1'b1;
        faults_nxt   = faults_r + 1'b1;
        res_slot_nxt = vic_idx_r;
        res_wb_nxt   = 1'b1;
        res_wbp_nxt  = vic_page_r;
        state_nxt    = ST_OUT;
      end

      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, faults_r, hits_r,
                           FIELD_PAGE_W'(res_wbp_r), res_wb_r, res_found_r,
                           FIELD_SLOT_W'(res_slot_r), res_hit_r};
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      rd_vld_r     <= 1'b0;
      slot_valid_r <= SLOTS'(1);
      wr_done_r    <= '0;
      lfsr_r       <= LFSR_SEED;
      hits_r       <= '0;
      faults_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      rd_vld_r     <= rd_vld_nxt;
      slot_valid_r <= slot_valid_nxt;
      wr_done_r    <= wr_done_nxt;
      lfsr_r       <= lfsr_nxt;
      hits_r       <= hits_nxt;
      faults_r     <= faults_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_p2_r     <= rd_p2_nxt;
    rd_idx_r    <= rd_idx_nxt;
    op_r        <= op_nxt;
    page_r      <= page_nxt;
    kind_r      <= kind_nxt;
    mt_fnd_r    <= mt_fnd_nxt;
    mt_idx_r    <= mt_idx_nxt;
    mt_cls_r    <= mt_cls_nxt;
    emp_fnd_r   <= emp_fnd_nxt;
    emp_idx_r   <= emp_idx_nxt;
    min_cls_r   <= min_cls_nxt;
    cls_cnt_r   <= cls_cnt_nxt;
    root_page_r <= root_page_nxt;
    root_cls_r  <= root_cls_nxt;
    tgt_r       <= tgt_nxt;
    vic_fnd_r   <= vic_fnd_nxt;
    vic_idx_r   <= vic_idx_nxt;
    vic_page_r  <= vic_page_nxt;
    res_hit_r   <= res_hit_nxt;
    res_slot_r  <= res_slot_nxt;
    res_found_r <= res_found_nxt;
    res_wb_r    <= res_wb_nxt;
    res_wbp_r   <= res_wbp_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  `NRU_ASSERT_NOW(a_root_valid, 1'b1, slot_valid_r[0], "root slot lost its valid bit")
  `NRU_ASSERT_NOW(a_mod_in_wait, mod_done, state_r == ST_MOD, "remainder done outside tie wait")
  `NRU_ASSERT_NOW(a_victim_ready, state_r == ST_VWR, vic_fnd_r, "eviction without a victim")
  `NRU_ASSERT_NEXT(a_out_load, state_r == ST_OUT && (!out_valid_r || out_tready), out_tvalid && state_r == ST_IDLE, "result word not loaded")

endmodule
